// ----- design/imsv_pkg.sv -----
`default_nettype none
package imsv_pkg;

  // Sample and fixed-point format
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int IN_W        = 16;
  localparam int NUM_CH      = 6;
  localparam int CH_W        = $clog2(NUM_CH);

  // Mean in signed fixed point, deviation magnitude fits in the same width
  localparam int MEAN_W      = SAMPLE_BITS + FRAC_BITS;
  localparam int MEAN_OUT_W  = 32;
  localparam int AD_W        = MEAN_W;

  // Variance and the serial divider's dividend width
  localparam int VAR_W       = 51;
  localparam int DIV_W       = VAR_W;
  localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

  // Sample limit register
  localparam int LIM_W       = 16;
  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(100);

  // Step counter covers the longest serial pass
  localparam int STEP_W      = $clog2(DIV_W);

  // Stream widths
  localparam int IN_TDATA_W  = ((NUM_CH * IN_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = MEAN_OUT_W + VAR_W;
  localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W = CH_W + 1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MLOAD,
    ST_MDIV,
    ST_MUPD,
    ST_DLOAD,
    ST_MUL,
    ST_SQLD,
    ST_VDIV,
    ST_T1LD,
    ST_S1DIV,
    ST_ULD,
    ST_S2DIV,
    ST_VUPD,
    ST_REPORT
  } ctrl_state_e;

  // Strobes from the sequencer to every channel lane
  typedef struct packed {
    logic mean_load;
    logic div_step;
    logic mean_upd;
    logic mul_load;
    logic mul_step;
    logic sq_load;
    logic t1_load;
    logic u_load;
    logic var_upd;
  } lane_ctrl_t;

endpackage
`default_nettype wire

// ----- design/imsv_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit per cycle while step_i is high
module imsv_div #(
  parameter int DVD_W = imsv_pkg::DIV_W,
  parameter int DVR_W = imsv_pkg::LIM_W
) (
  input  wire logic             clk_i,
  input  wire logic             load_i,
  input  wire logic [DVD_W-1:0] load_val_i,
  input  wire logic             step_i,
  input  wire logic [DVR_W-1:0] divisor_i,
  output logic      [DVD_W-1:0] quo_o,
  output logic                  rem_nz_o
);

  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVR_W-1:0] rem_q, rem_d;
  logic [DVR_W:0]   shifted;
  logic [DVR_W:0]   diff;
  logic             ge;

  // Trial subtract of the divisor from the partial remainder
  always_comb begin
    shifted = {rem_q, dvd_q[DVD_W-1]};
    diff    = shifted - {1'b0, divisor_i};
    ge      = (shifted >= {1'b0, divisor_i});
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    if (load_i) begin
      dvd_d = load_val_i;
      rem_d = '0;
    end else if (step_i) begin
      dvd_d = {dvd_q[DVD_W-2:0], ge};
      rem_d = ge ? diff[DVR_W-1:0] : shifted[DVR_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  // Quotient bits shift in where the dividend bits leave
  assign quo_o    = dvd_q;
  assign rem_nz_o = |rem_q;

endmodule
`default_nettype wire

// ----- design/imsv_mul.sv -----
`default_nettype none
// Shift-add multiplier, one multiplier bit per cycle while step_i is high
module imsv_mul #(
  parameter int OP_W = imsv_pkg::AD_W
) (
  input  wire logic              clk_i,
  input  wire logic              load_i,
  input  wire logic [OP_W-1:0]   load_val_i,
  input  wire logic              step_i,
  output logic      [2*OP_W-1:0] prod_o
);

  logic [OP_W-1:0] mcand_q, mcand_d;
  logic [OP_W-1:0] acc_q, acc_d;
  logic [OP_W-1:0] mplr_q, mplr_d;
  logic [OP_W:0]   sum;

  // Add the multiplicand on a set bit, then shift the pair right
  always_comb begin
    sum     = {1'b0, acc_q} + (mplr_q[0] ? {1'b0, mcand_q} : '0);
    mcand_d = mcand_q;
    acc_d   = acc_q;
    mplr_d  = mplr_q;
    if (load_i) begin
      mcand_d = load_val_i;
      acc_d   = '0;
      mplr_d  = load_val_i;
    end else if (step_i) begin
      acc_d  = sum[OP_W:1];
      mplr_d = {sum[0], mplr_q[OP_W-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    acc_q   <= acc_d;
    mplr_q  <= mplr_d;
  end

  assign prod_o = {acc_q, mplr_q};

endmodule
`default_nettype wire

// ----- design/imsv_lane.sv -----
`default_nettype none
// One channel: running mean and variance state with its serial units
module imsv_lane (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire imsv_pkg::lane_ctrl_t               ctrl_i,
  input  wire logic [imsv_pkg::LIM_W-1:0]         n_i,
  input  wire logic signed [imsv_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic signed [imsv_pkg::MEAN_W-1:0]      mean_o,
  output logic [imsv_pkg::VAR_W-1:0]              var_o
);

  localparam int MEAN_W = imsv_pkg::MEAN_W;
  localparam int VAR_W  = imsv_pkg::VAR_W;
  localparam int DIV_W  = imsv_pkg::DIV_W;
  localparam int AD_W   = imsv_pkg::AD_W;
  localparam int SQ_W   = 2 * AD_W - imsv_pkg::FRAC_BITS;
  localparam int CMP_W  = (SQ_W > VAR_W) ? SQ_W : VAR_W;

  logic signed [MEAN_W-1:0] xf;
  logic signed [MEAN_W-1:0] mean_q, mean_d;
  logic signed [MEAN_W-1:0] qm;
  logic [VAR_W-1:0]         var_q, var_d;
  logic [VAR_W-1:0]         t1_q, t1_d;
  logic [VAR_W-1:0]         sq_q, sq_d;
  logic                     neg_q, neg_d;

  logic signed [MEAN_W:0]   dpos, dneg;
  logic [MEAN_W:0]          dmag;

  logic                     div_load;
  logic [DIV_W-1:0]         div_val;
  logic [DIV_W-1:0]         quo;
  logic                     rem_nz;
  logic [VAR_W-1:0]         ceil_base;
  logic [VAR_W-1:0]         ceil_sub;
  logic [VAR_W:0]           var_sum;

  logic [2*AD_W-1:0]        prod;
  logic [SQ_W-1:0]          sq_raw;
  logic                     sq_big;
  logic [VAR_W-1:0]         sq_val;

  // Sample scaled to the mean's fixed-point format
  assign xf = $signed({sample_i, {imsv_pkg::FRAC_BITS{1'b0}}});

  // Deviation from the current mean, both signs in parallel
  assign dpos = (MEAN_W+1)'(xf) - (MEAN_W+1)'(mean_q);
  assign dneg = (MEAN_W+1)'(mean_q) - (MEAN_W+1)'(xf);
  assign dmag = dpos[MEAN_W] ? dneg : dpos;

  // Squared deviation, scaled and clamped
  assign sq_raw = prod[2*AD_W-1:imsv_pkg::FRAC_BITS];
  assign sq_big = CMP_W'(sq_raw) > CMP_W'(imsv_pkg::VAR_MAX);
  assign sq_val = sq_big ? imsv_pkg::VAR_MAX : VAR_W'(sq_raw);

  // x - ceil(x/n) from the finished quotient and remainder
  assign ceil_base = ctrl_i.t1_load ? var_q : sq_q;
  assign ceil_sub  = ceil_base - quo - VAR_W'(rem_nz);

  assign qm      = quo[MEAN_W-1:0];
  assign var_sum = {1'b0, t1_q} + {1'b0, quo[VAR_W-1:0]};

  // Divider operand select
  always_comb begin
    div_load = ctrl_i.mean_load | ctrl_i.sq_load | ctrl_i.t1_load | ctrl_i.u_load;
    div_val  = DIV_W'(dmag);
    if (ctrl_i.sq_load) begin
      div_val = DIV_W'(var_q);
    end else if (ctrl_i.t1_load) begin
      div_val = DIV_W'(sq_q);
    end else if (ctrl_i.u_load) begin
      div_val = DIV_W'(ceil_sub);
    end
  end

  imsv_div #(
    .DVD_W (DIV_W),
    .DVR_W (imsv_pkg::LIM_W)
  ) u_div (
    .clk_i      (clk_i),
    .load_i     (div_load),
    .load_val_i (div_val),
    .step_i     (ctrl_i.div_step),
    .divisor_i  (n_i),
    .quo_o      (quo),
    .rem_nz_o   (rem_nz)
  );

  imsv_mul #(
    .OP_W (AD_W)
  ) u_mul (
    .clk_i      (clk_i),
    .load_i     (ctrl_i.mul_load),
    .load_val_i (AD_W'(dmag)),
    .step_i     (ctrl_i.mul_step),
    .prod_o     (prod)
  );

  // State updates
  always_comb begin
    mean_d = mean_q;
    var_d  = var_q;
    t1_d   = t1_q;
    sq_d   = sq_q;
    neg_d  = neg_q;
    if (ctrl_i.mean_load) begin
      neg_d = dpos[MEAN_W];
    end
    // Truncating step toward zero
    if (ctrl_i.mean_upd) begin
      mean_d = neg_q ? (mean_q - qm) : (mean_q + qm);
    end
    if (ctrl_i.sq_load) begin
      sq_d = sq_val;
    end
    if (ctrl_i.t1_load) begin
      t1_d = ceil_sub;
    end
    if (ctrl_i.var_upd) begin
      var_d = var_sum[VAR_W] ? imsv_pkg::VAR_MAX : var_sum[VAR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q <= '0;
      var_q  <= '0;
    end else begin
      mean_q <= mean_d;
      var_q  <= var_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q  <= t1_d;
    sq_q  <= sq_d;
    neg_q <= neg_d;
  end

  assign mean_o = mean_q;
  assign var_o  = var_q;

endmodule
`default_nettype wire

// ----- design/imsv_ctrl.sv -----
`default_nettype none
// Sequencer: sample count, done flag, serial pass timing and report walk
module imsv_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [imsv_pkg::LIM_W-1:0]   cfg_wdata_i,
  input  wire logic                         s_tvalid_i,
  input  wire logic                         s_tlast_i,
  output logic                              s_tready_o,
  input  wire logic                         m_tready_i,
  output logic                              m_tvalid_o,
  output logic                              m_tlast_o,
  output logic [imsv_pkg::CH_W-1:0]         ch_o,
  output logic                              done_o,
  output logic [imsv_pkg::LIM_W-1:0]        n_o,
  output imsv_pkg::lane_ctrl_t              lane_ctrl_o
);

  localparam int STEP_W = imsv_pkg::STEP_W;
  localparam int LIM_W  = imsv_pkg::LIM_W;
  localparam int CH_W   = imsv_pkg::CH_W;

  imsv_pkg::ctrl_state_e state_q, state_d;
  logic [STEP_W-1:0]     cnt_q, cnt_d;
  logic [LIM_W-1:0]      limit_q, limit_d;
  logic [LIM_W-1:0]      count_q, count_d;
  logic                  done_q, done_d;
  logic                  rep_q, rep_d;
  logic [CH_W-1:0]       ch_q, ch_d;

  logic                  accept;
  logic                  take;
  logic                  div_last;
  logic                  mul_last;
  logic                  ch_last;
  logic [LIM_W-1:0]      n;

  assign accept   = s_tvalid_i && (state_q == imsv_pkg::ST_IDLE);
  assign take     = !done_q && (count_q < limit_q);
  assign div_last = (cnt_q == STEP_W'(imsv_pkg::DIV_W - 1));
  assign mul_last = (cnt_q == STEP_W'(imsv_pkg::AD_W - 1));
  assign ch_last  = (ch_q == CH_W'(imsv_pkg::NUM_CH - 1));
  assign n        = count_q + LIM_W'(1);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      imsv_pkg::ST_IDLE: begin
        if (accept) begin
          if (take) begin
            state_d = imsv_pkg::ST_MLOAD;
          end else if (s_tlast_i) begin
            state_d = imsv_pkg::ST_REPORT;
          end
        end
      end
      imsv_pkg::ST_MLOAD: state_d = imsv_pkg::ST_MDIV;
      imsv_pkg::ST_MDIV: begin
        if (div_last) state_d = imsv_pkg::ST_MUPD;
      end
      imsv_pkg::ST_MUPD:  state_d = imsv_pkg::ST_DLOAD;
      imsv_pkg::ST_DLOAD: state_d = imsv_pkg::ST_MUL;
      imsv_pkg::ST_MUL: begin
        if (mul_last) state_d = imsv_pkg::ST_SQLD;
      end
      imsv_pkg::ST_SQLD: state_d = imsv_pkg::ST_VDIV;
      imsv_pkg::ST_VDIV: begin
        if (div_last) state_d = imsv_pkg::ST_T1LD;
      end
      imsv_pkg::ST_T1LD: state_d = imsv_pkg::ST_S1DIV;
      imsv_pkg::ST_S1DIV: begin
        if (div_last) state_d = imsv_pkg::ST_ULD;
      end
      imsv_pkg::ST_ULD: state_d = imsv_pkg::ST_S2DIV;
      imsv_pkg::ST_S2DIV: begin
        if (div_last) state_d = imsv_pkg::ST_VUPD;
      end
      imsv_pkg::ST_VUPD: begin
        state_d = rep_q ? imsv_pkg::ST_REPORT : imsv_pkg::ST_IDLE;
      end
      imsv_pkg::ST_REPORT: begin
        if (m_tready_i && ch_last) state_d = imsv_pkg::ST_IDLE;
      end
      default: state_d = imsv_pkg::ST_IDLE;
    endcase
  end

  // Lane strobes and handshake outputs
  always_comb begin
    lane_ctrl_o = '0;
    s_tready_o  = 1'b0;
    m_tvalid_o  = 1'b0;
    unique case (state_q)
      imsv_pkg::ST_IDLE:   s_tready_o = 1'b1;
      imsv_pkg::ST_MLOAD:  lane_ctrl_o.mean_load = 1'b1;
      imsv_pkg::ST_MDIV:   lane_ctrl_o.div_step  = 1'b1;
      imsv_pkg::ST_MUPD:   lane_ctrl_o.mean_upd  = 1'b1;
      imsv_pkg::ST_DLOAD:  lane_ctrl_o.mul_load  = 1'b1;
      imsv_pkg::ST_MUL:    lane_ctrl_o.mul_step  = 1'b1;
      imsv_pkg::ST_SQLD:   lane_ctrl_o.sq_load   = 1'b1;
      imsv_pkg::ST_VDIV:   lane_ctrl_o.div_step  = 1'b1;
      imsv_pkg::ST_T1LD:   lane_ctrl_o.t1_load   = 1'b1;
      imsv_pkg::ST_S1DIV:  lane_ctrl_o.div_step  = 1'b1;
      imsv_pkg::ST_ULD:    lane_ctrl_o.u_load    = 1'b1;
      imsv_pkg::ST_S2DIV:  lane_ctrl_o.div_step  = 1'b1;
      imsv_pkg::ST_VUPD:   lane_ctrl_o.var_upd   = 1'b1;
      imsv_pkg::ST_REPORT: m_tvalid_o = 1'b1;
      default: begin
        lane_ctrl_o = '0;
      end
    endcase
  end

  // Step counter restarts on every state change
  assign cnt_d = (state_d == state_q) ? cnt_q + STEP_W'(1) : '0;

  // Limit register, sample count, done flag, report walk
  always_comb begin
    limit_d = cfg_we_i ? cfg_wdata_i : limit_q;
    count_d = count_q;
    done_d  = done_q;
    rep_d   = rep_q;
    ch_d    = ch_q;
    if (accept) begin
      rep_d = s_tlast_i;
      if (!done_q && !take) begin
        done_d = 1'b1;
      end
    end
    if (state_q == imsv_pkg::ST_VUPD) begin
      count_d = n;
      done_d  = (n >= limit_q);
    end
    if (state_q == imsv_pkg::ST_REPORT && m_tready_i) begin
      ch_d = ch_last ? '0 : ch_q + CH_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= imsv_pkg::ST_IDLE;
      cnt_q   <= '0;
      limit_q <= imsv_pkg::LIMIT_RESET;
      count_q <= '0;
      done_q  <= 1'b0;
      rep_q   <= 1'b0;
      ch_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      limit_q <= limit_d;
      count_q <= count_d;
      done_q  <= done_d;
      rep_q   <= rep_d;
      ch_q    <= ch_d;
    end
  end

  assign m_tlast_o = ch_last;
  assign ch_o      = ch_q;
  assign done_o    = done_q;
  assign n_o       = n;

endmodule
`default_nettype wire

// ----- design/imu_static_mean_variance_init.sv -----
// Operation: a sample that updates the statistics runs the mean, square and variance
//   passes before the first report result; six lanes run bit-serial dividers of 51 steps
//   (four passes) and a 32-step shift-add squarer in lockstep.
// Flow: one item at a time; no new sample is taken until the update and any report
//   of the six channels end; an ignored sample with group end reports on the next cycle.
// Reset: means, variances, sample count and done flag clear; the limit returns to 100.
`default_nettype none
module imu_static_mean_variance_init (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Sample limit register
  input  wire logic                                cfg_we_i,
  input  wire logic [imsv_pkg::LIM_W-1:0]          cfg_wdata_i,
  // Sample stream
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each)
  input  wire logic [imsv_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  wire logic                                s_axis_tlast,
  // Report stream
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // mean_value (32), variance_value (51), zero pad
  output logic [imsv_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  // channel (3), calib_done (1)
  output logic [imsv_pkg::OUT_TUSER_W-1:0]         m_axis_tuser,
  output logic                                     m_axis_tlast
);

  localparam int NUM_CH      = imsv_pkg::NUM_CH;
  localparam int SAMPLE_BITS = imsv_pkg::SAMPLE_BITS;
  localparam int IN_W        = imsv_pkg::IN_W;
  localparam int PAD_W       = imsv_pkg::OUT_TDATA_W - imsv_pkg::OUT_DATA_W;

  logic signed [SAMPLE_BITS-1:0]      sample_q [NUM_CH];
  logic signed [imsv_pkg::MEAN_W-1:0] mean_w [NUM_CH];
  logic [imsv_pkg::VAR_W-1:0]         var_w [NUM_CH];

  imsv_pkg::lane_ctrl_t               lane_ctrl;
  logic [imsv_pkg::LIM_W-1:0]         n;
  logic [imsv_pkg::CH_W-1:0]          ch;
  logic                               done;
  logic                               in_xfer;
  logic [imsv_pkg::MEAN_OUT_W-1:0]    mean_out;

  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // Capture the samples of an accepted transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      for (int i = 0; i < NUM_CH; i++) begin
        sample_q[i] <= s_axis_tdata[i*IN_W +: SAMPLE_BITS];
      end
    end
  end

  imsv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tlast_i   (s_axis_tlast),
    .s_tready_o  (s_axis_tready),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tlast_o   (m_axis_tlast),
    .ch_o        (ch),
    .done_o      (done),
    .n_o         (n),
    .lane_ctrl_o (lane_ctrl)
  );

  // One lane per channel
  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    imsv_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl),
      .n_i      (n),
      .sample_i (sample_q[g]),
      .mean_o   (mean_w[g]),
      .var_o    (var_w[g])
    );
  end

  // Report payload for the channel being walked
  assign mean_out     = imsv_pkg::MEAN_OUT_W'(mean_w[ch]);
  assign m_axis_tdata = {{PAD_W{1'b0}}, var_w[ch], mean_out};
  assign m_axis_tuser = {done, ch};

endmodule
`default_nettype wire
